// ===== design/rgba_laplacian_sharpen_3x3_macros.svh =====
// Assertion macros for the Laplacian sharpen block.
// No dependencies; included by files that carry concurrent checks.
`ifndef RGBA_LAPLACIAN_SHARPEN_3X3_MACROS_SVH
`define RGBA_LAPLACIAN_SHARPEN_3X3_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication
`define RLSH_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rlsh: same-cycle check failed");
// Next-cycle implication
`define RLSH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rlsh: next-cycle check failed");
`else
`define RLSH_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RLSH_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== design/rlsh_pkg.sv =====
// Shared types and constants for the RGBA Laplacian sharpen block.
// No dependencies.
`timescale 1ns / 1ps

package rlsh_pkg;

    // Register file geometry
    localparam int REG_W      = 12;
    localparam int ROW_W      = 12;
    localparam int EMIT_W     = 23;
    localparam int AREA_W     = 23;

    // Reset values of the registers
    localparam logic [REG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [REG_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [REG_W-1:0] GAIN_RESET   = 12'd256;
    localparam logic [AREA_W-1:0] AREA_RESET  = 23'd307200;

    // Frame height limit
    localparam logic [REG_W-1:0] LINES_LIMIT  = 12'd2048;

    // Register indexes on the config port
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_SHARPEN_GAIN = 2'd2
    } reg_index_t;

    // One RGBA pixel, red in the low byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    localparam int PIXEL_W = $bits(pixel_t);

endpackage

// ===== design/rlsh_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module rlsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, old data on a same-address collision
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/rgba_laplacian_sharpen_3x3.sv =====
// A result passes through stage 1, stage 2 and the output register after its beat.
// Throughput: one beat per clock if unstalled; line buffers read/write one entry per cycle.
// s_tready drops for one cycle after each config write while the frame area settles.
// Reset (aresetn low, synchronous) clears counters, valids, window and registers;
// s_tready and cfg_ready stay low during reset and for the first cycle after it.
// Line buffers are not cleared; no clearing pass, no startup delay.
`timescale 1ns / 1ps
`include "rgba_laplacian_sharpen_3x3_macros.svh"

module rgba_laplacian_sharpen_3x3 #(
    parameter int MAX_LINE_PIXELS = 2048
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Pixel input
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // in_red, in_green, in_blue, in_alpha
    input  logic                        s_tuser,   // pad
    // Pixel output
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic                        m_tlast,   // frame_end
    // Config writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  rlsh_pkg::reg_index_t        cfg_index,
    input  logic [rlsh_pkg::REG_W-1:0]  cfg_data
);

    import rlsh_pkg::*;

    localparam int AW   = $clog2(MAX_LINE_PIXELS);
    localparam int CNTW = ((AW > REG_W) ? AW : REG_W) + 1;

    // ---------------------------------------------------------------
    // Config registers
    // ---------------------------------------------------------------
    logic [REG_W-1:0]  frame_width_reg, frame_height_reg, sharpen_gain_reg;
    logic [REG_W-1:0]  eff_w, eff_h;
    logic [AREA_W-1:0] area_reg, area_next;
    logic              settle_reg;
    logic              cfg_ready_reg;
    logic              cfg_wr, geom_wr;

    // Config port opens once reset is released
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_ready_reg <= 1'b0;
        end else begin
            cfg_ready_reg <= 1'b1;
        end
    end

    assign cfg_ready = cfg_ready_reg;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign geom_wr   = cfg_wr && ((cfg_index == REG_FRAME_WIDTH) ||
                                  (cfg_index == REG_FRAME_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
            sharpen_gain_reg <= GAIN_RESET;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_SHARPEN_GAIN: sharpen_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective geometry: zero acts as one, oversize saturates
    always_comb begin
        if (frame_width_reg == '0) begin
            eff_w = REG_W'(1);
        end else if (CNTW'(frame_width_reg) > CNTW'(MAX_LINE_PIXELS)) begin
            eff_w = REG_W'(MAX_LINE_PIXELS);
        end else begin
            eff_w = frame_width_reg;
        end
        if (frame_height_reg == '0) begin
            eff_h = REG_W'(1);
        end else if (frame_height_reg > LINES_LIMIT) begin
            eff_h = LINES_LIMIT;
        end else begin
            eff_h = frame_height_reg;
        end
    end

    // Frame area, one register after the multiply
    assign area_next = AREA_W'(eff_w) * AREA_W'(eff_h);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_reg   <= AREA_RESET;
            settle_reg <= 1'b1;
        end else begin
            area_reg   <= area_next;
            settle_reg <= cfg_wr;
        end
    end

    // ---------------------------------------------------------------
    // Pipeline enable and input stage
    // ---------------------------------------------------------------
    logic en, accept;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en && !settle_reg;
    assign accept   = s_tvalid && s_tready;

    logic [AW-1:0]     col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [EMIT_W-1:0] emitted_reg;
    logic [CNTW-1:0]   col_inc;
    logic [ROW_W:0]    row_inc;
    logic              wrap0, emit0, interior0, fe0;
    pixel_t            px0;

    assign px0     = s_tuser ? '0 : pixel_t'(s_tdata);
    assign col_inc = CNTW'(col_reg) + CNTW'(1);
    assign row_inc = (ROW_W+1)'(row_reg) + (ROW_W+1)'(1);
    assign wrap0   = col_inc >= CNTW'(eff_w);

    // Position classification of the beat being taken
    assign emit0     = (row_reg >= ROW_W'(2)) || ((row_reg == ROW_W'(1)) && (col_reg != '0));
    assign interior0 = (CNTW'(col_reg) >= CNTW'(2)) && (col_inc <= CNTW'(eff_w)) &&
                       (row_reg >= ROW_W'(2)) && (row_inc <= (ROW_W+1)'(eff_h));
    assign fe0       = emit0 &&
                       (((EMIT_W+1)'(emitted_reg) + (EMIT_W+1)'(1)) >= (EMIT_W+1)'(area_reg));

    // Frame position and result counters
    always_ff @(posedge aclk) begin
        if (!aresetn || geom_wr) begin
            col_reg     <= '0;
            row_reg     <= '0;
            emitted_reg <= '0;
        end else if (accept) begin
            if (fe0) begin
                col_reg     <= '0;
                row_reg     <= '0;
                emitted_reg <= '0;
            end else begin
                col_reg <= wrap0 ? '0 : col_inc[AW-1:0];
                row_reg <= wrap0 ? row_inc[ROW_W-1:0] : row_reg;
                if (emit0) begin
                    emitted_reg <= emitted_reg + EMIT_W'(1);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: line buffer read data arrives, write back, window shift
    // ---------------------------------------------------------------
    logic          v1_reg, emit1_reg, int1_reg, fe1_reg;
    logic [AW-1:0] col1_reg;
    pixel_t        px1_reg;
    logic          byp_reg;
    pixel_t        fwd_top_reg, fwd_mid_reg;
    pixel_t        ram_top, ram_mid, top_eff, mid_eff;

    // Same-column read and write in one cycle (one-pixel lines): forward
    assign top_eff = byp_reg ? fwd_top_reg : ram_top;
    assign mid_eff = byp_reg ? fwd_mid_reg : ram_mid;

    rlsh_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_LINE_PIXELS)
    ) u_upper_line (
        .aclk    (aclk),
        .wr_en   (en && v1_reg),
        .wr_addr (col1_reg),
        .wr_data (mid_eff),
        .rd_en   (en),
        .rd_addr (col_reg),
        .rd_data (ram_top)
    );

    rlsh_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_LINE_PIXELS)
    ) u_middle_line (
        .aclk    (aclk),
        .wr_en   (en && v1_reg),
        .wr_addr (col1_reg),
        .wr_data (px1_reg),
        .rd_en   (en),
        .rd_addr (col_reg),
        .rd_data (ram_mid)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            byp_reg <= 1'b0;
        end else if (en) begin
            v1_reg  <= accept;
            byp_reg <= accept && v1_reg && (col_reg == col1_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px1_reg     <= px0;
            col1_reg    <= col_reg;
            emit1_reg   <= emit0;
            int1_reg    <= interior0;
            fe1_reg     <= fe0;
            fwd_top_reg <= mid_eff;
            fwd_mid_reg <= px1_reg;
        end
    end

    // 3x3 window: rows are upper, middle, current line; column 2 is newest
    pixel_t win_reg [3][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (en && v1_reg) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= top_eff;
            win_reg[1][2] <= mid_eff;
            win_reg[2][2] <= px1_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: sharpen the window center into the output register
    // ---------------------------------------------------------------
    logic v2_reg, int2_reg, fe2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg && emit1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            int2_reg <= int1_reg;
            fe2_reg  <= fe1_reg;
        end
    end

    // c + gain*(4c - N - S - E - W) in Q8, floored and clamped to a byte
    function automatic logic [7:0] sharpen(input logic [7:0] c, input logic [7:0] n,
                                           input logic [7:0] s, input logic [7:0] e,
                                           input logic [7:0] w,
                                           input logic [REG_W-1:0] gain);
        logic signed [11:0] lap;
        logic signed [25:0] prod;
        logic signed [26:0] sum;
        lap  = $signed({2'b00, c, 2'b00}) - $signed({4'b0000, n}) - $signed({4'b0000, s})
             - $signed({4'b0000, e}) - $signed({4'b0000, w});
        prod = 26'($signed({1'b0, gain}) * lap);
        sum  = 27'(prod) + $signed({11'd0, c, 8'd0});
        if (sum < 0) begin
            sharpen = 8'd0;
        end else if (sum[26:8] > 19'd255) begin
            sharpen = 8'd255;
        end else begin
            sharpen = sum[15:8];
        end
    endfunction

    pixel_t center, sharp_px, out_next;
    pixel_t out_data_reg;
    logic   m_tlast_reg;

    assign center = win_reg[1][1];

    always_comb begin
        sharp_px.red   = sharpen(center.red,   win_reg[0][1].red,   win_reg[2][1].red,
                                 win_reg[1][2].red,   win_reg[1][0].red,   sharpen_gain_reg);
        sharp_px.green = sharpen(center.green, win_reg[0][1].green, win_reg[2][1].green,
                                 win_reg[1][2].green, win_reg[1][0].green, sharpen_gain_reg);
        sharp_px.blue  = sharpen(center.blue,  win_reg[0][1].blue,  win_reg[2][1].blue,
                                 win_reg[1][2].blue,  win_reg[1][0].blue,  sharpen_gain_reg);
        sharp_px.alpha = center.alpha;
        out_next       = int2_reg ? sharp_px : center;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= out_next;
            m_tlast_reg  <= fe2_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `RLSH_ASSERT_NEXT(a_cfg_blocks_intake, aclk, aresetn, cfg_valid && cfg_ready, !s_tready)
    `RLSH_ASSERT_NEXT(a_frame_end_restart, aclk, aresetn, accept && fe0, ~|({col_reg, row_reg, emitted_reg}))
    `RLSH_ASSERT_IMPL(a_emitted_below_area, aclk, aresetn, !settle_reg, (AREA_W'(emitted_reg) < area_reg))

endmodule

// ===== tb/rgba_laplacian_sharpen_3x3_tb.sv =====
// Self-checking testbench for the RGBA 3x3 Laplacian sharpen block.
// Depends on rlsh_pkg and the rgba_laplacian_sharpen_3x3 top level; a built-in
// line-buffer predictor supplies the expected pixels.
`timescale 1ns / 1ps

module rgba_laplacian_sharpen_3x3_tb;

    localparam int MAX_LINE       = 2048;
    localparam int PIPE_LATENCY   = 2;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_LIMIT    = 100;
    localparam logic [1:0] REG_UNUSED_IDX = 2'd3;

    typedef struct {
        rlsh_pkg::pixel_t px;
        bit               frame_end;
    } sharpened_t;

    // DUT ports
    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [31:0]                 s_tdata;   // in_red, in_green, in_blue, in_alpha
    logic                        s_tuser;   // pad
    logic                        m_tvalid;
    logic                        m_tready;
    logic [31:0]                 m_tdata;   // out_red, out_green, out_blue, out_alpha
    logic                        m_tlast;   // frame_end
    logic                        cfg_valid;
    logic                        cfg_ready;
    rlsh_pkg::reg_index_t        cfg_index;
    logic [rlsh_pkg::REG_W-1:0]  cfg_data;

    // Predictor state: registers, line stores, window and frame position
    logic [11:0]      width_reg  = rlsh_pkg::WIDTH_RESET;
    logic [11:0]      height_reg = rlsh_pkg::HEIGHT_RESET;
    logic [11:0]      gain_reg   = rlsh_pkg::GAIN_RESET;
    rlsh_pkg::pixel_t line_upper  [MAX_LINE];
    rlsh_pkg::pixel_t line_middle [MAX_LINE];
    rlsh_pkg::pixel_t win [3][3];
    int               col_pos;
    int               row_pos;
    int               out_count;

    sharpened_t awaited_pixels[$];

    // Run bookkeeping
    int  mismatch_count;
    int  beats_in;
    int  results_checked;
    int  frames_done;
    int  reg_writes;
    int  stall_cycles;
    bit  source_gaps = 1'b1;
    bit  sink_gaps   = 1'b1;
    int  sink_hold_len;

    rgba_laplacian_sharpen_3x3 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Out-of-range geometry: 0 acts as 1, above the limit acts as the limit
    function automatic int eff_dim(logic [11:0] v);
        if (v == 0) return 1;
        if (v > MAX_LINE) return MAX_LINE;
        return int'(v);
    endfunction

    function automatic int frame_beats();
        int w;
        w = eff_dim(width_reg);
        return w * eff_dim(height_reg) + w + 1;
    endfunction

    function automatic void restart_frame_pos();
        col_pos   = 0;
        row_pos   = 0;
        out_count = 0;
    endfunction

    // c + gain*(4c - N - S - E - W) in Q.8, floored and clamped to 0..255
    function automatic logic [7:0] sharpen_chan(int c, int n, int s, int e, int w);
        int acc;
        acc = 256 * c + int'(gain_reg) * (4 * c - n - s - e - w);
        if (acc < 0) return 8'd0;
        acc = acc >>> 8;
        if (acc > 255) return 8'd255;
        return acc[7:0];
    endfunction

    // Advance the window by one accepted beat and queue the pixel it releases
    function automatic void predict_beat(rlsh_pkg::pixel_t px_in, bit pad);
        int               w, h, c, r;
        rlsh_pkg::pixel_t px, top, mid;
        bit               emit, interior;
        sharpened_t       res;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        c = col_pos;
        r = row_pos;
        px = pad ? '0 : px_in;
        if (c >= MAX_LINE) c = MAX_LINE - 1;
        top = line_upper[c];
        mid = line_middle[c];
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = px;
        line_upper[c]  = mid;
        line_middle[c] = px;

        emit     = (r >= 2) || (r == 1 && c >= 1);
        interior = (c >= 2) && (c <= w - 1) && (r >= 2) && (r <= h - 1);

        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
        end
        if (!emit) return;

        res.px = win[1][1];
        if (interior) begin
            res.px.red   = sharpen_chan(win[1][1].red, win[0][1].red, win[2][1].red,
                                        win[1][0].red, win[1][2].red);
            res.px.green = sharpen_chan(win[1][1].green, win[0][1].green, win[2][1].green,
                                        win[1][0].green, win[1][2].green);
            res.px.blue  = sharpen_chan(win[1][1].blue, win[0][1].blue, win[2][1].blue,
                                        win[1][0].blue, win[1][2].blue);
        end
        if (out_count + 1 >= w * h) begin
            res.frame_end = 1'b1;
            restart_frame_pos();
        end else begin
            res.frame_end = 1'b0;
            out_count++;
        end
        awaited_pixels.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            if (mismatch_count < PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        sharpened_t       want;
        rlsh_pkg::pixel_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = rlsh_pkg::pixel_t'(m_tdata);
            if (awaited_pixels.size() == 0) begin
                if (mismatch_count < PRINT_LIMIT)
                    $display("%0t: unexpected beat, expected none, actual %h last %b",
                             $time, m_tdata, m_tlast);
                mismatch_count++;
            end else begin
                want = awaited_pixels.pop_front();
                check_field("red",       want.px.red,     got.red);
                check_field("green",     want.px.green,   got.green);
                check_field("blue",      want.px.blue,    got.blue);
                check_field("alpha",     want.px.alpha,   got.alpha);
                check_field("frame_end", want.frame_end,  m_tlast);
                if (m_tlast) frames_done++;
                results_checked++;
            end
        end
    end

    // Watchdog on cycles with no accepted beat on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, stall_cycles);
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Result sink: random stalls per beat, or one long hold-off on request
    initial begin : result_sink
        int idle_n;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            idle_n = sink_gaps ? $urandom_range(0, 19) : 0;
            if (sink_hold_len > 0) begin
                idle_n = sink_hold_len;
                sink_hold_len = 0;
            end
            if (idle_n > 0) begin
                m_tready <= 1'b0;
                repeat (idle_n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [7:0] random_level();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic rlsh_pkg::pixel_t random_pixel();
        rlsh_pkg::pixel_t px;
        px.red   = random_level();
        px.green = random_level();
        px.blue  = random_level();
        px.alpha = random_level();
        return px;
    endfunction

    function automatic logic [11:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 12'd0;
            1:       return 12'd4095;
            2:       return 12'd256;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // One input beat; s_tvalid stays high on return so the next beat can follow at once
    task automatic send_beat(rlsh_pkg::pixel_t px, bit pad);
        int gap;
        gap = source_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= pad;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_in++;
        predict_beat(px, pad);
    endtask

    // Beats [first, first+count) of a frame: pixels, then the flush pads
    task automatic send_frame(int first, int count, int pad_pct, int real_flush_pct);
        int area;
        area = eff_dim(width_reg) * eff_dim(height_reg);
        for (int i = first; i < first + count; i++) begin
            if (i < area)
                send_beat(random_pixel(), $urandom_range(0, 99) < pad_pct);
            else
                send_beat(random_pixel(), !($urandom_range(0, 99) < real_flush_pct));
        end
    endtask

    // Stop the source and let every pending result drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaited_pixels.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 6) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= rlsh_pkg::reg_index_t'(idx);
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            rlsh_pkg::REG_FRAME_WIDTH: begin
                width_reg = value;
                restart_frame_pos();
            end
            rlsh_pkg::REG_FRAME_HEIGHT: begin
                height_reg = value;
                restart_frame_pos();
            end
            rlsh_pkg::REG_SHARPEN_GAIN: gain_reg = value;
            default: ;
        endcase
    endtask

    task automatic set_geometry(int w, int h);
        write_reg(rlsh_pkg::REG_FRAME_WIDTH, 12'(w));
        write_reg(rlsh_pkg::REG_FRAME_HEIGHT, 12'(h));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Smallest frame with an interior pixel, gain left at its reset value
    task automatic test_reset_gain();
        set_geometry(3, 3);
        send_frame(0, frame_beats(), 0, 0);
    endtask

    // Checkerboards at full gain drive the interior to both clamp limits
    task automatic test_saturation();
        rlsh_pkg::pixel_t px;
        set_geometry(4, 4);
        write_reg(rlsh_pkg::REG_SHARPEN_GAIN, 12'd4095);
        for (int y = 0; y < 4; y++) begin
            for (int x = 0; x < 4; x++) begin
                px.red   = ((x + y) % 2 == 1) ? 8'hFF : 8'h00;
                px.green = ~px.red;
                px.blue  = (x == y) ? 8'hFF : 8'h00;
                px.alpha = random_level();
                send_beat(px, 1'b0);
            end
        end
        for (int i = 0; i <= 4; i++) send_beat(random_pixel(), 1'b1);
    endtask

    // Zero gain: every pixel comes back untouched
    task automatic test_zero_gain();
        set_geometry(3, 5);
        write_reg(rlsh_pkg::REG_SHARPEN_GAIN, 12'd0);
        send_frame(0, frame_beats(), 0, 0);
    endtask

    // Width or height of zero acts as one; a single-pixel frame
    task automatic test_degenerate_geometry();
        write_reg(rlsh_pkg::REG_SHARPEN_GAIN, 12'd384);
        set_geometry(0, 2);
        send_frame(0, frame_beats(), 0, 0);
        set_geometry(3, 0);
        send_frame(0, frame_beats(), 0, 0);
        set_geometry(1, 1);
        send_frame(0, frame_beats(), 0, 0);
    endtask

    // A write to an unused index must change nothing
    task automatic test_unknown_register();
        set_geometry(3, 3);
        write_reg(REG_UNUSED_IDX, 12'hA5C);
        send_frame(0, frame_beats(), 0, 0);
    endtask

    // Geometry write in mid-frame restarts the frame
    task automatic test_restart_on_geometry();
        set_geometry(5, 4);
        send_frame(0, 9, 0, 0);
        write_reg(rlsh_pkg::REG_FRAME_HEIGHT, 12'd4);
        send_frame(0, frame_beats(), 0, 0);
    endtask

    // Gain write in mid-frame applies at once without a restart
    task automatic test_gain_mid_frame();
        set_geometry(5, 5);
        write_reg(rlsh_pkg::REG_SHARPEN_GAIN, 12'd128);
        send_frame(0, 14, 0, 0);
        write_reg(rlsh_pkg::REG_SHARPEN_GAIN, 12'd1000);
        send_frame(14, frame_beats() - 14, 0, 0);
    endtask

    // Pads inside the frame and real pixels inside the flush
    task automatic test_pads_in_frame();
        set_geometry(6, 3);
        send_frame(0, frame_beats(), 25, 50);
    endtask

    // Sink holds off for a long stretch while the source keeps offering
    task automatic test_output_stall();
        set_geometry(16, 6);
        source_gaps   = 1'b0;
        sink_hold_len = 400;
        send_frame(0, frame_beats(), 0, 0);
        settle();
        source_gaps = 1'b1;
    endtask

    // Out-of-range width and height over partial frames, each cut by a geometry write
    task automatic test_large_geometry();
        source_gaps = 1'b0;
        sink_gaps   = 1'b0;
        write_reg(rlsh_pkg::REG_SHARPEN_GAIN, pick_gain());
        set_geometry(4095, 3);
        send_frame(0, 40, 0, 0);
        set_geometry(3, 4095);
        send_frame(0, 90, 0, 0);
        settle();
        source_gaps = 1'b1;
        sink_gaps   = 1'b1;
    endtask

    // Mostly whole frames of random content, some broken or reconfigured mid-way
    task automatic test_random_frames(int beat_goal);
        int start_beats, w, h, total, cut;
        bit first;
        start_beats = beats_in;
        first = 1'b1;
        while (beats_in - start_beats < beat_goal) begin
            source_gaps = ($urandom_range(0, 2) != 0);
            sink_gaps   = ($urandom_range(0, 2) != 0);
            if (first || $urandom_range(0, 1) == 0) begin
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12);
                h = $urandom_range(1, 6);
                set_geometry(w, h);
                first = 1'b0;
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(rlsh_pkg::REG_SHARPEN_GAIN, pick_gain());
            total = frame_beats();
            case ($urandom_range(0, 9))
                7: send_frame(0, total, 12, 30);
                8: begin
                    cut = $urandom_range(1, total - 1);
                    send_frame(0, cut, 0, 0);
                    write_reg(rlsh_pkg::REG_FRAME_WIDTH, width_reg);
                end
                9: begin
                    cut = $urandom_range(1, total - 1);
                    send_frame(0, cut, 0, 0);
                    write_reg(rlsh_pkg::REG_SHARPEN_GAIN, pick_gain());
                    send_frame(cut, total - cut, 0, 0);
                end
                default: send_frame(0, total, 0, 0);
            endcase
        end
        settle();
        source_gaps = 1'b1;
        sink_gaps   = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : test_sequence
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= rlsh_pkg::REG_FRAME_WIDTH;
        cfg_data  <= '0;
        for (int i = 0; i < MAX_LINE; i++) begin
            line_upper[i]  = '0;
            line_middle[i] = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) win[i][j] = '0;
        restart_frame_pos();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_gain();
        test_saturation();
        test_zero_gain();
        test_degenerate_geometry();
        test_unknown_register();
        test_restart_on_geometry();
        test_gain_mid_frame();
        test_pads_in_frame();
        test_output_stall();
        test_large_geometry();
        test_random_frames(720);

        settle();
        repeat (16) @(posedge aclk);
        if (awaited_pixels.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, awaited_pixels.size());
            mismatch_count++;
        end
        $display("Sent %0d input beats over %0d register writes; checked %0d output beats",
                 beats_in, reg_writes, results_checked);
        $display("in %0d complete frames, %0d mismatches", frames_done, mismatch_count);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
